@@ hw/rtl/jsst_pkg.sv @@
// Shared definitions for the job shop schedule timer.
// Field widths, request codes, controller states and stage control structs.
// No dependencies; every other file refers to this package by scoped names.
package jsst_pkg;

  // Request field widths
  localparam int OP_W    = 2;
  localparam int JOB_W   = 6;
  localparam int STEP_W  = 6;
  localparam int MACH_W  = 4;
  localparam int PTIME_W = 16;
  localparam int TVAL_W  = 16;
  localparam int OUT_W   = 32;

  // Default sizing
  localparam int MACHINES_DEF  = 16;
  localparam int JOBS_DEF      = 64;
  localparam int TIME_BITS_DEF = 32;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_SCHED = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_RUN,
    ST_DRAIN
  } ctl_state_t;

  // Control into the evaluation stage
  typedef struct packed {
    logic valid;
    logic use_delay;
  } s2_ctl_t;

  // Status back from the evaluation stage
  typedef struct packed {
    logic hold;
    logic advance;
  } s2_stat_t;

  // Address width for a store of n entries, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

@@ hw/rtl/jsst_in_if.sv @@
// Request channel of the job shop schedule timer: valid/ready plus request fields.
// Depends on jsst_pkg for the field widths.
interface jsst_in_if;
  logic                         valid;
  logic                         ready;
  logic [jsst_pkg::OP_W-1:0]    op;
  logic [jsst_pkg::JOB_W-1:0]   job_index;
  logic [jsst_pkg::STEP_W-1:0]  step_index;
  logic [jsst_pkg::MACH_W-1:0]  machine;
  logic [jsst_pkg::PTIME_W-1:0] proc_time;
  logic [jsst_pkg::MACH_W-1:0]  from_machine;
  logic [jsst_pkg::TVAL_W-1:0]  transport_value;

  modport source (
    output valid, op, job_index, step_index, machine, proc_time, from_machine,
           transport_value,
    input  ready
  );

  modport sink (
    input  valid, op, job_index, step_index, machine, proc_time, from_machine,
           transport_value,
    output ready
  );
endinterface

@@ hw/rtl/jsst_out_if.sv @@
// Result channel of the job shop schedule timer: valid/ready plus result fields.
// Depends on jsst_pkg for the field widths.
interface jsst_out_if;
  logic                       valid;
  logic                       ready;
  logic [jsst_pkg::OUT_W-1:0] start_time;
  logic [jsst_pkg::OUT_W-1:0] done_time;
  logic [jsst_pkg::OUT_W-1:0] makespan;
  logic                       overflow;

  modport source (
    output valid, start_time, done_time, makespan, overflow,
    input  ready
  );

  modport sink (
    input  valid, start_time, done_time, makespan, overflow,
    output ready
  );
endinterface

@@ hw/rtl/job_shop_schedule_timer_top.sv @@
// Job shop schedule timer with transport delays: top level.
// Holds the request decode, the sweep controller, the forwarding stage and the
// write-back path. Depends on jsst_pkg, jsst_in_if, jsst_out_if,
// jsst_state_mem, jsst_xport_mem and jsst_eval.
//
// Usage:
//   sched_in carries requests (schedule, load transport entry, clear).
//   result_out carries one result per in-range schedule request, in order.
//   Schedule requests pass stage 1, stage 2 and the result register. Unless
//   stalled, throughput is one request per cycle; job and machine entries go
//   through a read, an evaluation and a write-back, and the last two writes
//   are forwarded so that back-to-back operations of one job or machine chain.
//   Load requests write the transport table directly and give no result;
//   requests out of range and unused codes are dropped.
//   A clear request waits for operations in flight to drain, then zeroes job
//   and machine entries, up to max(JOBS, MACHINES), with sched_in.ready low.
//   The same sweep runs after reset. The transport table is not cleared.
//   When result_out stalls, the result is held and the pipeline keeps taking
//   requests until its stages fill, then ready drops.
module job_shop_schedule_timer_top #(
  parameter int MACHINES  = jsst_pkg::MACHINES_DEF,
  parameter int JOBS      = jsst_pkg::JOBS_DEF,
  parameter int TIME_BITS = jsst_pkg::TIME_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  jsst_in_if.sink    sched_in,
  jsst_out_if.source result_out
);
  localparam int MIDX_W  = jsst_pkg::idx_w(MACHINES);
  localparam int JIDX_W  = jsst_pkg::idx_w(JOBS);
  localparam int SWEEP_N = (JOBS > MACHINES) ? JOBS : MACHINES;
  localparam int CNT_W   = jsst_pkg::idx_w(SWEEP_N);
  localparam int JE_W    = TIME_BITS + MIDX_W + 1;

  jsst_pkg::ctl_state_t state;
  jsst_pkg::ctl_state_t state_next;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_next;

  logic acc, job_ok, mach_ok, from_ok;
  logic sched_acc, load_acc, clear_acc;
  logic hold1, p1_move;

  // Stage 1: request with memory reads in flight
  logic                         p1_valid;
  logic [JIDX_W-1:0]            p1_job;
  logic [MIDX_W-1:0]            p1_mach;
  logic                         p1_step_nz;
  logic [jsst_pkg::PTIME_W-1:0] p1_ptime;

  // Stage 2: evaluation
  logic                         p2_valid;
  logic [JIDX_W-1:0]            p2_job;
  logic [MIDX_W-1:0]            p2_mach;
  logic [jsst_pkg::PTIME_W-1:0] p2_ptime;
  logic [TIME_BITS-1:0]         p2_fin;
  logic [TIME_BITS-1:0]         p2_mfree;
  logic                         p2_use_delay;

  // Last write-back
  logic                 wb_valid;
  logic [JIDX_W-1:0]    wb_job;
  logic [MIDX_W-1:0]    wb_mach;
  logic [TIME_BITS-1:0] wb_fin;

  // Memory ports
  logic [JE_W-1:0]      job_rdata, job_wdata;
  logic [TIME_BITS-1:0] mach_rdata, mach_wdata;
  logic                 job_we, mach_we;
  logic [JIDX_W-1:0]    job_waddr;
  logic [MIDX_W-1:0]    mach_waddr;
  logic [jsst_pkg::TVAL_W-1:0] delay;

  // Stage 1 resolved values
  logic [TIME_BITS-1:0] jr_fin;
  logic [MIDX_W-1:0]    jr_prev;
  logic                 jr_seen;
  logic                 seen1;
  logic [MIDX_W-1:0]    prev1;
  logic [TIME_BITS-1:0] fin1, mfree1;

  // Stage 2 resolved values
  logic [TIME_BITS-1:0] jf2, mf2;

  jsst_pkg::s2_ctl_t    ev_ctl;
  jsst_pkg::s2_stat_t   ev_stat;
  logic [TIME_BITS-1:0] ev_fin;

  // Decode the request
  assign acc       = sched_in.valid && sched_in.ready;
  assign job_ok    = 32'(sched_in.job_index) < JOBS;
  assign mach_ok   = 32'(sched_in.machine) < MACHINES;
  assign from_ok   = 32'(sched_in.from_machine) < MACHINES;
  assign sched_acc = acc && (sched_in.op == jsst_pkg::OP_SCHED) && job_ok && mach_ok;
  assign load_acc  = acc && (sched_in.op == jsst_pkg::OP_LOAD) && from_ok && mach_ok;
  assign clear_acc = acc && (sched_in.op == jsst_pkg::OP_CLEAR);

  assign hold1   = p1_valid && ev_stat.hold;
  assign p1_move = p1_valid && !hold1;
  assign sched_in.ready = (state == jsst_pkg::ST_RUN) && !hold1;

  // Controller state and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsst_pkg::ST_SWEEP;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      jsst_pkg::ST_RUN: begin
        if (clear_acc) begin
          state_next = jsst_pkg::ST_DRAIN;
        end
      end
      jsst_pkg::ST_DRAIN: begin
        if (!p1_valid && !p2_valid) begin
          state_next = jsst_pkg::ST_SWEEP;
          cnt_next   = '0;
        end
      end
      jsst_pkg::ST_SWEEP: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(SWEEP_N - 1)) begin
          state_next = jsst_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = jsst_pkg::ST_SWEEP;
        cnt_next   = '0;
      end
    endcase
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= sched_acc || hold1;
    end
  end

  always_ff @(posedge clk) begin
    if (sched_acc) begin
      p1_job     <= JIDX_W'(sched_in.job_index);
      p1_mach    <= MIDX_W'(sched_in.machine);
      p1_step_nz <= |sched_in.step_index;
      p1_ptime   <= sched_in.proc_time;
    end
  end

  // Forward into stage 1: the operation in stage 2, then the last write-back
  assign {jr_fin, jr_prev, jr_seen} = job_rdata;

  always_comb begin
    seen1  = jr_seen;
    prev1  = jr_prev;
    fin1   = jr_fin;
    mfree1 = mach_rdata;
    if (wb_valid && (wb_job == p1_job)) begin
      seen1 = 1'b1;
      prev1 = wb_mach;
      fin1  = wb_fin;
    end
    if (p2_valid && (p2_job == p1_job)) begin
      seen1 = 1'b1;
      prev1 = p2_mach;
    end
    if (wb_valid && (wb_mach == p1_mach)) begin
      mfree1 = wb_fin;
    end
  end

  // Stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (!ev_stat.hold) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      p2_job       <= p1_job;
      p2_mach      <= p1_mach;
      p2_ptime     <= p1_ptime;
      p2_fin       <= fin1;
      p2_mfree     <= mfree1;
      p2_use_delay <= p1_step_nz && seen1;
    end
  end

  // Forward into stage 2 from the write-back of the previous operation
  assign jf2 = (wb_valid && (wb_job == p2_job)) ? wb_fin : p2_fin;
  assign mf2 = (wb_valid && (wb_mach == p2_mach)) ? wb_fin : p2_mfree;

  assign ev_ctl.valid     = p2_valid;
  assign ev_ctl.use_delay = p2_use_delay;

  // Write-back record
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (state == jsst_pkg::ST_SWEEP) begin
      wb_valid <= 1'b0;
    end else if (ev_stat.advance) begin
      wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_stat.advance) begin
      wb_job  <= p2_job;
      wb_mach <= p2_mach;
      wb_fin  <= ev_fin;
    end
  end

  // Memory writes: sweep zeroes entries, otherwise write back the finish
  always_comb begin
    job_we     = 1'b0;
    job_waddr  = p2_job;
    job_wdata  = {ev_fin, p2_mach, 1'b1};
    mach_we    = 1'b0;
    mach_waddr = p2_mach;
    mach_wdata = ev_fin;
    if (state == jsst_pkg::ST_SWEEP) begin
      job_we     = 32'(cnt) < JOBS;
      job_waddr  = cnt[JIDX_W-1:0];
      job_wdata  = '0;
      mach_we    = 32'(cnt) < MACHINES;
      mach_waddr = cnt[MIDX_W-1:0];
      mach_wdata = '0;
    end else if (ev_stat.advance) begin
      job_we  = 1'b1;
      mach_we = 1'b1;
    end
  end

  jsst_state_mem #(
    .MACHINES  (MACHINES),
    .JOBS      (JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_state_mem (
    .clk        (clk),
    .rd_en      (sched_acc),
    .job_raddr  (JIDX_W'(sched_in.job_index)),
    .mach_raddr (MIDX_W'(sched_in.machine)),
    .job_rdata  (job_rdata),
    .mach_rdata (mach_rdata),
    .job_we     (job_we),
    .job_waddr  (job_waddr),
    .job_wdata  (job_wdata),
    .mach_we    (mach_we),
    .mach_waddr (mach_waddr),
    .mach_wdata (mach_wdata)
  );

  jsst_xport_mem #(
    .MACHINES (MACHINES)
  ) u_xport_mem (
    .clk   (clk),
    .we    (load_acc),
    .waddr ({MIDX_W'(sched_in.from_machine), MIDX_W'(sched_in.machine)}),
    .wdata (sched_in.transport_value),
    .re    (p1_move),
    .raddr ({prev1, p1_mach}),
    .rdata (delay)
  );

  jsst_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ev_ctl),
    .job_fin   (jf2),
    .mach_free (mf2),
    .ptime     (p2_ptime),
    .delay     (delay),
    .ms_clr    (state == jsst_pkg::ST_SWEEP),
    .stat      (ev_stat),
    .fin       (ev_fin),
    .res       (result_out)
  );

  // No operation is in flight while entries are being zeroed
  a_sweep_empty: assert property (@(posedge clk) disable iff (rst)
    state == jsst_pkg::ST_SWEEP |-> !p1_valid && !p2_valid)
    else $error("operation in flight during sweep");

  // Requests resume only after the sweep reached its last entry
  a_sweep_done: assert property (@(posedge clk) disable iff (rst)
    $rose(state == jsst_pkg::ST_RUN) |-> $past(cnt) == CNT_W'(SWEEP_N - 1))
    else $error("sweep ended early");

  // An operation leaving evaluation shows up as a result
  a_deliver: assert property (@(posedge clk) disable iff (rst)
    p2_valid && !ev_stat.hold |=> result_out.valid)
    else $error("evaluated operation produced no result");

endmodule

@@ hw/rtl/jsst_state_mem.sv @@
// Per-solution state memories: job entries (finish, previous machine, seen) and
// machine free times. One registered read port and one write port each.
// Depends on jsst_pkg.
module jsst_state_mem #(
  parameter int MACHINES  = jsst_pkg::MACHINES_DEF,
  parameter int JOBS      = jsst_pkg::JOBS_DEF,
  parameter int TIME_BITS = jsst_pkg::TIME_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rd_en,
  input  logic [jsst_pkg::idx_w(JOBS)-1:0]             job_raddr,
  input  logic [jsst_pkg::idx_w(MACHINES)-1:0]         mach_raddr,
  output logic [TIME_BITS+jsst_pkg::idx_w(MACHINES):0] job_rdata,
  output logic [TIME_BITS-1:0]                         mach_rdata,
  input  logic                                         job_we,
  input  logic [jsst_pkg::idx_w(JOBS)-1:0]             job_waddr,
  input  logic [TIME_BITS+jsst_pkg::idx_w(MACHINES):0] job_wdata,
  input  logic                                         mach_we,
  input  logic [jsst_pkg::idx_w(MACHINES)-1:0]         mach_waddr,
  input  logic [TIME_BITS-1:0]                         mach_wdata
);
  localparam int JE_W = TIME_BITS + jsst_pkg::idx_w(MACHINES) + 1;

  logic [JE_W-1:0]      job_mem  [JOBS];
  logic [TIME_BITS-1:0] mach_mem [MACHINES];

  // Job entries: write, then registered read
  always_ff @(posedge clk) begin
    if (job_we) begin
      job_mem[job_waddr] <= job_wdata;
    end
    if (rd_en) begin
      job_rdata <= job_mem[job_raddr];
    end
  end

  // Machine free times: write, then registered read
  always_ff @(posedge clk) begin
    if (mach_we) begin
      mach_mem[mach_waddr] <= mach_wdata;
    end
    if (rd_en) begin
      mach_rdata <= mach_mem[mach_raddr];
    end
  end

endmodule

@@ hw/rtl/jsst_xport_mem.sv @@
// Transport delay table, addressed by {source machine, destination machine}.
// One write port, one registered read port. Depends on jsst_pkg.
module jsst_xport_mem #(
  parameter int MACHINES = jsst_pkg::MACHINES_DEF
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [2*jsst_pkg::idx_w(MACHINES)-1:0]     waddr,
  input  logic [jsst_pkg::TVAL_W-1:0]                wdata,
  input  logic                                       re,
  input  logic [2*jsst_pkg::idx_w(MACHINES)-1:0]     raddr,
  output logic [jsst_pkg::TVAL_W-1:0]                rdata
);
  localparam int DEPTH = 1 << (2 * jsst_pkg::idx_w(MACHINES));

  logic [jsst_pkg::TVAL_W-1:0] xport_mem [DEPTH];

  // Load entries and read the delay for the next operation
  always_ff @(posedge clk) begin
    if (we) begin
      xport_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= xport_mem[raddr];
    end
  end

endmodule

@@ hw/rtl/jsst_eval.sv @@
// Evaluation stage: saturating job-ready and finish times, start selection,
// running makespan and the result register. Depends on jsst_pkg, jsst_out_if.
module jsst_eval #(
  parameter int TIME_BITS = jsst_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  jsst_pkg::s2_ctl_t            ctl,
  input  logic [TIME_BITS-1:0]         job_fin,
  input  logic [TIME_BITS-1:0]         mach_free,
  input  logic [jsst_pkg::PTIME_W-1:0] ptime,
  input  logic [jsst_pkg::TVAL_W-1:0]  delay,
  input  logic                         ms_clr,
  output jsst_pkg::s2_stat_t           stat,
  output logic [TIME_BITS-1:0]         fin,
  jsst_out_if.source                   res
);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [TIME_BITS:0]         ready_sum;
  logic [TIME_BITS:0]         fin_sum;
  logic [TIME_BITS-1:0]       ready_t;
  logic [TIME_BITS-1:0]       start_t;
  logic [TIME_BITS-1:0]       ms;
  logic [TIME_BITS-1:0]       ms_next;
  logic                       ready_ovf;
  logic                       fin_ovf;
  logic                       out_valid;
  logic [jsst_pkg::OUT_W-1:0] out_start;
  logic [jsst_pkg::OUT_W-1:0] out_finish;
  logic [jsst_pkg::OUT_W-1:0] out_ms;
  logic                       out_ovf;

  // Compute ready, start, finish; clamp both sums at the maximum time
  always_comb begin
    ready_sum = {1'b0, job_fin}
              + (TIME_BITS+1)'(ctl.use_delay ? delay : jsst_pkg::TVAL_W'(0));
    ready_ovf = ready_sum[TIME_BITS];
    ready_t   = ready_ovf ? TMAX : ready_sum[TIME_BITS-1:0];
    start_t   = (mach_free > ready_t) ? mach_free : ready_t;
    fin_sum   = {1'b0, start_t} + (TIME_BITS+1)'(ptime);
    fin_ovf   = fin_sum[TIME_BITS];
    fin       = fin_ovf ? TMAX : fin_sum[TIME_BITS-1:0];
    ms_next   = (fin > ms) ? fin : ms;
  end

  // Stall while the result register is full and not taken
  assign stat.hold    = ctl.valid && out_valid && !res.ready;
  assign stat.advance = ctl.valid && !stat.hold;

  // Running makespan
  always_ff @(posedge clk) begin
    if (rst || ms_clr) begin
      ms <= '0;
    end else if (stat.advance) begin
      ms <= ms_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.advance) begin
      out_start  <= jsst_pkg::OUT_W'(start_t);
      out_finish <= jsst_pkg::OUT_W'(fin);
      out_ms     <= jsst_pkg::OUT_W'(ms_next);
      out_ovf    <= ready_ovf || fin_ovf;
    end
  end

  assign res.valid      = out_valid;
  assign res.start_time = out_start;
  assign res.done_time  = out_finish;
  assign res.makespan   = out_ms;
  assign res.overflow   = out_ovf;

  // Makespan only grows between clears
  a_ms_mono: assert property (@(posedge clk) disable iff (rst)
    !ms_clr |=> ms >= $past(ms))
    else $error("makespan decreased without a clear");

  // Makespan covers every finish that left the stage
  a_ms_cover: assert property (@(posedge clk) disable iff (rst)
    stat.advance && !ms_clr |=> ms >= $past(fin))
    else $error("makespan below a delivered finish time");

endmodule

@@ tb/tb.sv @@
// Self-checking bench for job_shop_schedule_timer_top: directed rows, random schedules,
// transport loads and clears, and a back-to-back chain of one job across two machines.
// Depends on jsst_pkg, jsst_in_if, jsst_out_if and the RTL of the block.
module tb;

  localparam int MACH_N         = jsst_pkg::MACHINES_DEF;
  localparam int JOB_N          = jsst_pkg::JOBS_DEF;
  localparam int TIME_W         = jsst_pkg::TIME_BITS_DEF;
  localparam int OP_W           = jsst_pkg::OP_W;
  localparam int JOB_W          = jsst_pkg::JOB_W;
  localparam int STEP_W         = jsst_pkg::STEP_W;
  localparam int MACH_W         = jsst_pkg::MACH_W;
  localparam int PTIME_W        = jsst_pkg::PTIME_W;
  localparam int TVAL_W         = jsst_pkg::TVAL_W;
  localparam int OUT_W          = jsst_pkg::OUT_W;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 800;
  localparam int CHAIN_OPS      = 80;
  localparam int CHAIN_JOB      = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 12;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [JOB_W-1:0]   job_index;
    logic [STEP_W-1:0]  step_index;
    logic [MACH_W-1:0]  machine;
    logic [PTIME_W-1:0] proc_time;
    logic [MACH_W-1:0]  from_machine;
    logic [TVAL_W-1:0]  transport_value;
  } sched_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] start_time;
    logic [OUT_W-1:0] done_time;
    logic [OUT_W-1:0] makespan;
    logic             overflow;
  } sched_res_t;

  // A request's typed-in answer, used instead of the predicted one when set
  typedef struct packed {
    bit         typed;
    sched_res_t res;
  } answer_t;

  typedef struct {
    sched_req_t req;
    answer_t    note;
  } plan_row_t;

  logic clk;
  logic rst = 1'b1;

  jsst_in_if  sched_in ();
  jsst_out_if result_out ();

  job_shop_schedule_timer_top uut (
    .clk        (clk),
    .rst        (rst),
    .sched_in   (sched_in),
    .result_out (result_out)
  );

  // Predicted schedule state
  logic [TIME_W-1:0] mach_free_at  [MACH_N];
  logic [TIME_W-1:0] job_done_at   [JOB_N];
  bit                job_started   [JOB_N];
  logic [MACH_W-1:0] job_last_mach [JOB_N];
  logic [TVAL_W-1:0] route_delay   [MACH_N*MACH_N];
  logic [TIME_W-1:0] span_so_far;

  // What the stimulus side has issued so far, to keep transport reads on loaded entries
  bit                plan_job_seen  [JOB_N];
  logic [MACH_W-1:0] plan_job_mach  [JOB_N];
  logic [STEP_W-1:0] plan_next_step [JOB_N];
  bit                route_loaded   [MACH_N*MACH_N];
  logic [MACH_W-1:0] plan_last_mach = '0;

  sched_res_t due_times [$];
  answer_t    typed_answers [$];
  plan_row_t  directed_rows [$];
  int         mismatches  = 0;
  int         idle_cycles = 0;
  bit         steady_flow = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_solution_state();
    foreach (mach_free_at[i]) mach_free_at[i] = '0;
    foreach (job_done_at[i]) begin
      job_done_at[i]   = '0;
      job_started[i]   = 1'b0;
      job_last_mach[i] = '0;
    end
    span_so_far = '0;
  endfunction

  // Add with clamp at all ones; the top bit flags the clamp
  function automatic logic [TIME_W:0] clamp_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? {1'b1, {TIME_W{1'b1}}} : sum;
  endfunction

  // Apply one accepted request to the predicted state; returns 1 when it yields a result
  function automatic bit evaluate_request(input sched_req_t r, output sched_res_t res);
    logic [TVAL_W-1:0] delay;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] ready, start, finish;
    bit                sat;
    res = '0;
    sat = 1'b0;
    delay = '0;
    case (r.op)
      jsst_pkg::OP_LOAD: begin
        route_delay[{r.from_machine, r.machine}] = r.transport_value;
        return 1'b0;
      end
      jsst_pkg::OP_CLEAR: begin
        clear_solution_state();
        return 1'b0;
      end
      jsst_pkg::OP_SCHED: begin
        // Transport only from the job's previous machine, and never on step 0
        if (r.step_index != '0 && job_started[r.job_index])
          delay = route_delay[{job_last_mach[r.job_index], r.machine}];
        sum = clamp_add(job_done_at[r.job_index], TIME_W'(delay));
        sat |= sum[TIME_W];
        ready = sum[TIME_W-1:0];
        start = (mach_free_at[r.machine] > ready) ? mach_free_at[r.machine] : ready;
        sum = clamp_add(start, TIME_W'(r.proc_time));
        sat |= sum[TIME_W];
        finish = sum[TIME_W-1:0];
        mach_free_at[r.machine]    = finish;
        job_done_at[r.job_index]   = finish;
        job_started[r.job_index]   = 1'b1;
        job_last_mach[r.job_index] = r.machine;
        if (finish > span_so_far) span_so_far = finish;
        res.start_time = start;
        res.done_time  = finish;
        res.makespan   = span_so_far;
        res.overflow   = sat;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string label, input logic [OUT_W-1:0] want,
                                      input logic [OUT_W-1:0] seen);
    if (seen !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, seen);
    end
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PTIME_W-1:0] pick_time();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 7) return PTIME_W'($urandom_range(0, 255));
    return PTIME_W'($urandom);
  endfunction

  // Check results and predict requests, both as seen at the clock edge
  always @(posedge clk) begin
    sched_req_t seen_req;
    sched_res_t want, model_res;
    answer_t    note;
    if (!rst && result_out.valid && result_out.ready) begin
      if (due_times.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected nothing, got %0h %0h %0h %0b",
                 $time, result_out.start_time, result_out.done_time,
                 result_out.makespan, result_out.overflow);
      end else begin
        want = due_times.pop_front();
        check_field("start_time", want.start_time, result_out.start_time);
        check_field("done_time", want.done_time, result_out.done_time);
        check_field("makespan", want.makespan, result_out.makespan);
        check_field("overflow", OUT_W'(want.overflow), OUT_W'(result_out.overflow));
      end
    end
    if (!rst && sched_in.valid && sched_in.ready) begin
      seen_req.op              = sched_in.op;
      seen_req.job_index       = sched_in.job_index;
      seen_req.step_index      = sched_in.step_index;
      seen_req.machine         = sched_in.machine;
      seen_req.proc_time       = sched_in.proc_time;
      seen_req.from_machine    = sched_in.from_machine;
      seen_req.transport_value = sched_in.transport_value;
      note = typed_answers.pop_front();
      if (evaluate_request(seen_req, model_res))
        due_times.push_back(note.typed ? note.res : model_res);
    end
    // Watchdog on cycles with no handshake on either side
    if ((sched_in.valid && sched_in.ready) || (result_out.valid && result_out.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no handshake in %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: alternate runs of ready with random stalls
  initial begin
    result_out.ready <= 1'b0;
    @(posedge clk);
    forever begin
      int stall;
      stall = pick_gap();
      if (stall != 0) begin
        result_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_out.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Offer one request and hold it until accepted; valid stays high afterwards
  task automatic drive_request(input sched_req_t r, input answer_t note);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      sched_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_answers.push_back(note);
    case (r.op)
      jsst_pkg::OP_SCHED: begin
        plan_job_seen[r.job_index]  = 1'b1;
        plan_job_mach[r.job_index]  = r.machine;
        plan_next_step[r.job_index] = r.step_index + STEP_W'(1);
        plan_last_mach              = r.machine;
      end
      jsst_pkg::OP_LOAD: route_loaded[{r.from_machine, r.machine}] = 1'b1;
      jsst_pkg::OP_CLEAR: begin
        foreach (plan_job_seen[i]) begin
          plan_job_seen[i]  = 1'b0;
          plan_next_step[i] = '0;
        end
      end
      default: ;
    endcase
    sched_in.valid           <= 1'b1;
    sched_in.op              <= r.op;
    sched_in.job_index       <= r.job_index;
    sched_in.step_index      <= r.step_index;
    sched_in.machine         <= r.machine;
    sched_in.proc_time       <= r.proc_time;
    sched_in.from_machine    <= r.from_machine;
    sched_in.transport_value <= r.transport_value;
    do @(posedge clk); while (!sched_in.ready);
  endtask

  // Load the transport entry a schedule request would read, if it was never loaded
  task automatic issue(input sched_req_t r, input answer_t note);
    sched_req_t route;
    if (r.op == jsst_pkg::OP_SCHED && r.step_index != '0 && plan_job_seen[r.job_index] &&
        !route_loaded[{plan_job_mach[r.job_index], r.machine}]) begin
      route                 = '0;
      route.op              = jsst_pkg::OP_LOAD;
      route.job_index       = JOB_W'($urandom);
      route.from_machine    = plan_job_mach[r.job_index];
      route.machine         = r.machine;
      route.transport_value = pick_time();
      drive_request(route, '0);
    end
    drive_request(r, note);
  endtask

  // Drop valid and hold until every predicted result has arrived
  task automatic wait_for_results();
    sched_in.valid <= 1'b0;
    do @(negedge clk); while (due_times.size() != 0);
    @(posedge clk);
  endtask

  task automatic plan(input logic [OP_W-1:0] op, input logic [JOB_W-1:0] job,
                      input logic [STEP_W-1:0] step, input logic [MACH_W-1:0] mach,
                      input logic [PTIME_W-1:0] ptime, input logic [MACH_W-1:0] from,
                      input logic [TVAL_W-1:0] tval);
    plan_row_t row;
    row.req  = {op, job, step, mach, ptime, from, tval};
    row.note = '0;
    directed_rows.push_back(row);
  endtask

  task automatic plan_answer(input logic [OUT_W-1:0] start, input logic [OUT_W-1:0] finish,
                             input logic [OUT_W-1:0] span, input logic ovf);
    directed_rows[directed_rows.size()-1].note = {1'b1, start, finish, span, ovf};
  endtask

  initial begin
    sched_req_t r;
    int         roll;
    sched_in.valid           <= 1'b0;
    sched_in.op              <= jsst_pkg::OP_SCHED;
    sched_in.job_index       <= '0;
    sched_in.step_index      <= '0;
    sched_in.machine         <= '0;
    sched_in.proc_time       <= '0;
    sched_in.from_machine    <= '0;
    sched_in.transport_value <= '0;
    clear_solution_state();
    foreach (route_delay[i]) route_delay[i] = '0;
    foreach (plan_next_step[i]) plan_next_step[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Extremes after reset, transport chaining, first operations, clears, spare code
    plan(jsst_pkg::OP_SCHED, 0, 0, 0, 16'h0000, 0, 0);
    plan_answer(32'h0, 32'h0, 32'h0, 1'b0);
    plan(jsst_pkg::OP_SCHED, 63, 0, 15, 16'hFFFF, 0, 0);
    plan_answer(32'h0, 32'hFFFF, 32'hFFFF, 1'b0);
    plan(jsst_pkg::OP_LOAD, 42, 21, 0, 16'h1234, 15, 16'hFFFF);
    plan(jsst_pkg::OP_SCHED, 63, 63, 0, 16'h0001, 0, 0);
    plan_answer(32'h1FFFE, 32'h1FFFF, 32'h1FFFF, 1'b0);
    plan(jsst_pkg::OP_LOAD, 0, 0, 0, 16'h0000, 0, 16'h0007);
    plan(jsst_pkg::OP_SCHED, 0, 1, 0, 16'h0005, 0, 0);
    plan(OP_SPARE, 63, 63, 15, 16'hFFFF, 15, 16'hFFFF);
    plan(jsst_pkg::OP_SCHED, 1, 9, 3, 16'd100, 0, 0);
    plan(jsst_pkg::OP_SCHED, 1, 0, 0, 16'h0002, 0, 0);
    plan(jsst_pkg::OP_CLEAR, 63, 63, 15, 16'hFFFF, 15, 16'hFFFF);
    plan(jsst_pkg::OP_SCHED, 63, 1, 15, 16'h0002, 0, 0);
    plan_answer(32'h0, 32'h2, 32'h2, 1'b0);
    plan(jsst_pkg::OP_LOAD, 0, 0, 15, 16'h0000, 15, 16'h0000);
    plan(jsst_pkg::OP_SCHED, 63, 2, 15, 16'h0003, 0, 0);
    plan(jsst_pkg::OP_LOAD, 21, 42, 5, 16'hFFFF, 10, 16'h5A5A);
    plan(jsst_pkg::OP_LOAD, 42, 21, 10, 16'h0000, 5, 16'hA5A5);
    plan(jsst_pkg::OP_SCHED, 21, 0, 5, 16'hAAAA, 10, 16'h5555);
    plan(jsst_pkg::OP_SCHED, 42, 0, 10, 16'h5555, 5, 16'hAAAA);
    plan(jsst_pkg::OP_SCHED, 21, 1, 10, 16'h0001, 0, 0);
    plan(jsst_pkg::OP_SCHED, 42, 1, 5, 16'h0000, 0, 0);
    plan(OP_SPARE, 0, 0, 0, 16'h0000, 0, 0);
    plan(jsst_pkg::OP_CLEAR, 0, 0, 0, 16'h0000, 0, 0);
    plan(jsst_pkg::OP_SCHED, 0, 0, 0, 16'hFFFF, 0, 0);
    plan_answer(32'h0, 32'hFFFF, 32'hFFFF, 1'b0);
    foreach (directed_rows[i]) issue(directed_rows[i].req, directed_rows[i].note);

    // Random part: mostly in-order operations of a few jobs, with loads, clears and noise
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 49) == 0) wait_for_results();
      roll = $urandom_range(0, 99);
      r.op              = OP_SPARE;
      r.job_index       = JOB_W'($urandom);
      r.step_index      = STEP_W'($urandom);
      r.machine         = MACH_W'($urandom);
      r.proc_time       = PTIME_W'($urandom);
      r.from_machine    = MACH_W'($urandom);
      r.transport_value = TVAL_W'($urandom);
      if (roll < 80) begin
        r.op = jsst_pkg::OP_SCHED;
        if ($urandom_range(0, 3) != 0) r.job_index = JOB_W'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 8) r.step_index = plan_next_step[r.job_index];
        if ($urandom_range(0, 3) == 0) r.machine = plan_last_mach;
        r.proc_time = pick_time();
      end else if (roll < 91) begin
        r.op              = jsst_pkg::OP_LOAD;
        r.transport_value = pick_time();
      end else if (roll < 95) begin
        r.op = jsst_pkg::OP_CLEAR;
      end
      issue(r, '0);
    end

    // Back-to-back chain of one job across two machines with full transport delays
    wait_for_results();
    r = '0;
    r.op = jsst_pkg::OP_CLEAR;
    issue(r, '0);
    r.op              = jsst_pkg::OP_LOAD;
    r.from_machine    = 0;
    r.machine         = 1;
    r.transport_value = '1;
    issue(r, '0);
    r.from_machine = 1;
    r.machine      = 0;
    issue(r, '0);
    steady_flow = 1'b1;
    for (int k = 0; k < CHAIN_OPS; k++) begin
      r            = '0;
      r.op         = jsst_pkg::OP_SCHED;
      r.job_index  = JOB_W'(CHAIN_JOB);
      r.step_index = STEP_W'(k % 63 + 1);
      r.machine    = MACH_W'(k % 2);
      r.proc_time  = '1;
      issue(r, '0);
    end
    steady_flow = 1'b0;
    // Continue the same job with assorted times
    for (int k = 0; k < 12; k++) begin
      r            = '0;
      r.op         = jsst_pkg::OP_SCHED;
      r.job_index  = JOB_W'(CHAIN_JOB);
      r.step_index = STEP_W'(k + 1);
      r.machine    = MACH_W'($urandom_range(0, 1));
      r.proc_time  = pick_time();
      issue(r, '0);
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ job_shop_schedule_timer_top.f @@
hw/rtl/jsst_pkg.sv
hw/rtl/jsst_in_if.sv
hw/rtl/jsst_out_if.sv
hw/rtl/jsst_state_mem.sv
hw/rtl/jsst_xport_mem.sv
hw/rtl/jsst_eval.sv
hw/rtl/job_shop_schedule_timer_top.sv
tb/tb.sv
